@@ rtl/bbcct_pkg.sv @@
package bbcct_pkg;

    // Fixed field widths of one request.
    localparam int unsigned FileW  = 32;
    localparam int unsigned ChunkW = 32;
    localparam int unsigned SizeW  = 25;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_GET   = 2'd1,
        KIND_EVICT = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIM,
        S_OLD,
        S_KEY,
        S_DEC,
        S_FIT,
        S_INC,
        S_INS,
        S_EVF,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        hit;
        logic [5:0]  entry;
        logic [6:0]  evicted;
        logic [30:0] total;
    } t_result;

endpackage

@@ rtl/byte_budget_chunk_cache_tags.sv @@
// Tag and size manager for a chunk cache with a byte budget and oldest-first
// eviction. A request arrives on the s_ stream: s_tuser carries the kind (put,
// get, evict one file, clear) and s_tdata the file tag, chunk number and size.
// Each request yields exactly one result on the m_ stream: m_tuser is the hit
// flag and m_tdata holds the entry number, the eviction count and the byte
// total. The budget is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while idle, since the block itself does not enforce it. All
// entry state sits in one synchronous RAM that is walked one slot at a time
// (address, then registered read data). A get or a clean put takes one key
// pass; a put adds an age pass plus one pass per removed entry; evict-file
// adds an age pass per removed entry. Only one request is in flight at a
// time.
// Reset empties the table, zeroes the byte total and restores the budget to
// 64 MiB; no clearing pass is needed since validity lives in flip-flops.
// A finished result waits in an output register; while the receiver stalls,
// the next request is still accepted and worked on, and it holds in its last
// state only until the output register frees up.
module byte_budget_chunk_cache_tags #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // file_tag[31:0], chunk_number[63:32], chunk_bytes[88:64]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // entry[5:0], evicted[12:6], total_bytes[43:13]
    output logic [0:0]  m_tuser,   // hit[0]
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import bbcct_pkg::*;

    logic [31:0] r_budget;
    logic        r_out_valid;
    t_result     r_out;
    logic        core_idle;
    logic        core_done;
    logic        out_space;
    t_result     core_result;

    // The output register can take a new result when empty or being drained.
    assign out_space = !r_out_valid || m_tready;
    assign s_tready  = core_idle;

    bbcct_core #(
        .ENTRIES (ENTRIES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_tvalid && core_idle),
        .i_kind      (t_kind'(s_tuser)),
        .i_file      (s_tdata[31:0]),
        .i_chunk     (s_tdata[63:32]),
        .i_size      (s_tdata[88:64]),
        .i_budget    (r_budget),
        .i_out_space (out_space),
        .o_idle      (core_idle),
        .o_done      (core_done),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget    <= 32'd67108864;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_budget <= i_cfg_wdata;
            end
            if (core_done) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_done) begin
            r_out <= core_result;
        end
    end

    assign m_tvalid   = r_out_valid;
    assign m_tuser[0] = r_out.hit;
    assign m_tdata    = {4'd0, r_out.total, r_out.evicted, r_out.entry};

endmodule

@@ rtl/bbcct_core.sv @@
module bbcct_core #(
    parameter int unsigned ENTRIES = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  bbcct_pkg::t_kind        i_kind,
    input  logic [31:0]             i_file,
    input  logic [31:0]             i_chunk,
    input  logic [24:0]             i_size,
    input  logic [31:0]             i_budget,
    input  logic                    i_out_space,
    output logic                    o_idle,
    output logic                    o_done,
    output bbcct_pkg::t_result      o_result
);
    import bbcct_pkg::*;

    localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW   = $clog2(ENTRIES + 1);
    localparam int unsigned TW   = SizeW + CW;
    localparam int unsigned DW   = FileW + ChunkW + SizeW + IW;
    localparam int unsigned CMPW = TW + 2;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // One word per slot: file tag, chunk number, size and age (0 is newest).
    logic [DW-1:0]      r_mem [ENTRIES];
    logic [DW-1:0]      r_rdata;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [DW-1:0]      mem_wdata;

    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [FileW-1:0]   r_file, n_file;
    logic [ChunkW-1:0]  r_chunk, n_chunk;
    logic [SizeW-1:0]   r_size, n_size;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [CW-1:0]      r_live, n_live;
    logic [TW-1:0]      r_total, n_total;
    logic [CW-1:0]      r_evicted, n_evicted;
    logic               r_hit, n_hit;
    logic [IW-1:0]      r_entry, n_entry;
    logic [IW-1:0]      r_idx, n_idx;
    logic               r_wait, n_wait;
    logic               r_ret_fit, n_ret_fit;
    logic [IW-1:0]      r_aref, n_aref;
    logic [IW-1:0]      r_save, n_save;
    logic [IW-1:0]      r_free, n_free;
    logic               r_free_found, n_free_found;

    logic [FileW-1:0]   rd_file;
    logic [ChunkW-1:0]  rd_chunk;
    logic [SizeW-1:0]   rd_size;
    logic [IW-1:0]      rd_age;
    logic               cur_valid, key_match, old_match, file_match, last;
    logic               over_trim, put_need;

    assign rd_file    = r_rdata[FileW-1:0];
    assign rd_chunk   = r_rdata[FileW+ChunkW-1:FileW];
    assign rd_size    = r_rdata[FileW+ChunkW+SizeW-1:FileW+ChunkW];
    assign rd_age     = r_rdata[DW-1:FileW+ChunkW+SizeW];
    assign cur_valid  = r_valid[r_idx];
    assign key_match  = cur_valid && (rd_file == r_file) && (rd_chunk == r_chunk);
    assign file_match = cur_valid && (rd_file == r_file);
    assign old_match  = cur_valid && (CW'(rd_age) == (r_live - CW'(1)));
    assign last       = (r_idx == LAST);
    assign over_trim  = (CMPW'(r_total) > CMPW'(i_budget)) && (r_live != '0);
    assign put_need   = ((CMPW'(r_total) + CMPW'(r_size) > CMPW'(i_budget))
                        || (r_live >= CW'(ENTRIES))) && (r_live != '0);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_idx];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_TRIM;
            S_TRIM: begin
                if (over_trim) begin
                    n_state = S_OLD;
                end else begin
                    unique case (r_kind)
                        KIND_PUT, KIND_GET: n_state = S_KEY;
                        KIND_EVICT:         n_state = S_EVF;
                        KIND_CLEAR:         n_state = S_DONE;
                    endcase
                end
            end
            S_OLD: if (!r_wait && old_match) n_state = r_ret_fit ? S_FIT : S_TRIM;
            S_KEY: begin
                if (!r_wait) begin
                    if (key_match) begin
                        n_state = (r_kind == KIND_GET) ? S_DONE : S_DEC;
                    end else if (last) begin
                        n_state = (r_kind == KIND_GET) ? S_DONE : S_FIT;
                    end
                end
            end
            S_DEC: begin
                if (!r_wait && last) begin
                    if (r_kind == KIND_PUT) n_state = S_FIT;
                    else n_state = (r_save == LAST) ? S_DONE : S_EVF;
                end
            end
            S_FIT: n_state = put_need ? S_OLD : S_INC;
            S_INC: if (!r_wait && last) n_state = S_INS;
            S_INS: n_state = S_DONE;
            S_EVF: begin
                if (!r_wait) begin
                    if (file_match) n_state = S_DEC;
                    else if (last)  n_state = S_DONE;
                end
            end
            S_DONE: if (i_out_space) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory port.
    always_comb begin
        n_kind       = r_kind;
        n_file       = r_file;
        n_chunk      = r_chunk;
        n_size       = r_size;
        n_valid      = r_valid;
        n_live       = r_live;
        n_total      = r_total;
        n_evicted    = r_evicted;
        n_hit        = r_hit;
        n_entry      = r_entry;
        n_idx        = r_idx;
        n_wait       = 1'b0;
        n_ret_fit    = r_ret_fit;
        n_aref       = r_aref;
        n_save       = r_save;
        n_free       = r_free;
        n_free_found = r_free_found;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = r_rdata;
        o_done       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind    = i_kind;
                    n_file    = i_file;
                    n_chunk   = i_chunk;
                    n_size    = i_size;
                    n_evicted = '0;
                    n_hit     = 1'b0;
                    n_entry   = '0;
                end
            end
            S_TRIM: begin
                n_idx  = '0;
                n_wait = 1'b1;
                if (over_trim) begin
                    n_ret_fit = 1'b0;
                end else if (r_kind == KIND_CLEAR) begin
                    n_evicted = r_evicted + r_live;
                    n_valid   = '0;
                    n_live    = '0;
                    n_total   = '0;
                end
            end
            S_OLD, S_KEY, S_EVF: begin
                if (!r_wait) begin
                    if ((r_state == S_OLD && old_match)
                        || (r_state == S_KEY && key_match && r_kind == KIND_PUT)
                        || (r_state == S_EVF && file_match)) begin
                        // Remove the entry under the scan pointer.
                        n_valid[r_idx] = 1'b0;
                        n_total        = r_total - TW'(rd_size);
                        n_live         = r_live - CW'(1);
                        n_evicted      = r_evicted + CW'(1);
                        n_aref         = rd_age;
                        n_save         = r_idx;
                        if (r_state != S_OLD) begin
                            n_idx  = '0;
                            n_wait = 1'b1;
                        end
                    end else if (r_state == S_KEY && key_match) begin
                        n_hit   = 1'b1;
                        n_entry = r_idx;
                    end else if (!last) begin
                        n_idx  = r_idx + IW'(1);
                        n_wait = 1'b1;
                    end
                end
            end
            S_DEC: begin
                if (!r_wait) begin
                    if (cur_valid && rd_age > r_aref) begin
                        mem_we    = 1'b1;
                        mem_wdata = {rd_age - IW'(1), rd_size, rd_chunk, rd_file};
                    end
                    if (!last) begin
                        n_idx  = r_idx + IW'(1);
                        n_wait = 1'b1;
                    end else if (r_kind != KIND_PUT && r_save != LAST) begin
                        n_idx  = r_save + IW'(1);
                        n_wait = 1'b1;
                    end
                end
            end
            S_FIT: begin
                n_idx        = '0;
                n_wait       = 1'b1;
                n_ret_fit    = 1'b1;
                n_free_found = 1'b0;
            end
            S_INC: begin
                if (!r_wait) begin
                    if (cur_valid) begin
                        mem_we    = 1'b1;
                        mem_wdata = {rd_age + IW'(1), rd_size, rd_chunk, rd_file};
                    end else if (!r_free_found) begin
                        n_free_found = 1'b1;
                        n_free       = r_idx;
                    end
                    if (!last) begin
                        n_idx  = r_idx + IW'(1);
                        n_wait = 1'b1;
                    end
                end
            end
            S_INS: begin
                mem_we          = 1'b1;
                mem_waddr       = r_free;
                mem_wdata       = {IW'(0), r_size, r_chunk, r_file};
                n_valid[r_free] = 1'b1;
                n_total         = r_total + TW'(r_size);
                n_live          = r_live + CW'(1);
                n_entry         = r_free;
            end
            S_DONE: o_done = i_out_space;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_live    <= '0;
            r_total   <= '0;
            r_wait    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_live    <= n_live;
            r_total   <= n_total;
            r_wait    <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_file       <= n_file;
        r_chunk      <= n_chunk;
        r_size       <= n_size;
        r_evicted    <= n_evicted;
        r_hit        <= n_hit;
        r_entry      <= n_entry;
        r_idx        <= n_idx;
        r_ret_fit    <= n_ret_fit;
        r_aref       <= n_aref;
        r_save       <= n_save;
        r_free       <= n_free;
        r_free_found <= n_free_found;
    end

    assign o_idle           = (r_state == S_IDLE);
    assign o_result.hit     = r_hit;
    assign o_result.entry   = 6'(r_entry);
    assign o_result.evicted = 7'(r_evicted);
    assign o_result.total   = 31'(r_total);

endmodule
